>>> hw/rtl/bhbs_pkg.sv
// Shared constants, types and helpers of the byte histogram bar scaler.
`default_nettype none

package bhbs_pkg;

    localparam int NUM_BINS   = 256;
    localparam int COUNT_BITS = 32;
    localparam int IDX_BITS   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int BYTE_BITS  = 8;
    localparam int BAR_BITS   = 6;
    localparam int OUT_BITS   = 32;
    localparam int PROD_BITS  = COUNT_BITS + BAR_BITS;
    localparam int STEP_BITS  = $clog2(BAR_BITS);

    localparam logic [1:0] ACT_COUNT = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [63:0] OUT_MAX = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic load;
        logic clear;
        logic update;
        logic mul;
        logic div;
        logic finish;
    } bhbs_cmd_t;

    function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        if (w > OUT_MAX)
        begin
            return '1;
        end
        return w[OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bhbs_regs.sv
// APB configuration register block holding bar_width.
`default_nettype none

module bhbs_regs
    import bhbs_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [2:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output logic      [BAR_BITS-1:0] bar_width
);

    localparam logic REG_BAR_WIDTH = 1'b0;
    localparam logic [BAR_BITS-1:0] BAR_WIDTH_RESET = BAR_BITS'(63);

    logic [BAR_BITS-1:0] bar_width_reg;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BAR_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_width_reg <= BAR_WIDTH_RESET;
        end
        else if (wr_en)
        begin
            bar_width_reg <= pwdata[BAR_BITS-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_BAR_WIDTH)
        begin
            prdata = 32'(bar_width_reg);
        end
    end

    assign bar_width = bar_width_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bhbs_ctrl.sv
// Controller state machine sequencing count, query and clear items.
`default_nettype none

module bhbs_ctrl
    import bhbs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] action,
    output logic            busy,
    output bhbs_cmd_t       cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_UPDATE = 5'b00010,
        ST_MUL    = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic                 accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (accept)
                begin
                    unique case (action)
                        ACT_COUNT:
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_UPDATE;
                        end
                        ACT_QUERY:
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_MUL;
                        end
                        ACT_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div   = 1'b1;
                step_next = STEP_BITS'(step_reg + 1'b1);
                if (step_reg == STEP_BITS'(BAR_BITS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bhbs_datapath.sv
// Datapath: bin store, largest and total counters, bar multiply and divide.
`default_nettype none

module bhbs_datapath
    import bhbs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire bhbs_cmd_t            cmd,
    input  wire logic [BYTE_BITS-1:0] byte_value,
    input  wire logic [BAR_BITS-1:0]  bar_width,
    output logic                      done,
    output logic      [BYTE_BITS-1:0] bin_index,
    output logic      [OUT_BITS-1:0]  bin_count,
    output logic      [BAR_BITS-1:0]  bar_length,
    output logic                      printable,
    output logic      [OUT_BITS-1:0]  total_count
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [BYTE_BITS-1:0]  PRINT_LO  = 8'h20;
    localparam logic [BYTE_BITS-1:0]  PRINT_HI  = 8'h7E;

    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [NUM_BINS-1:0]   valid_reg;

    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [BYTE_BITS-1:0]  byte_reg;
    logic                  in_range_reg;
    logic [COUNT_BITS-1:0] largest_reg;
    logic [COUNT_BITS-1:0] total_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [PROD_BITS-1:0]  rem_reg;
    logic [PROD_BITS-1:0]  divr_reg;
    logic [BAR_BITS-1:0]   quot_reg;
    logic                  zero_div_reg;
    logic                  done_reg;
    logic [BYTE_BITS-1:0]  bin_index_reg;
    logic [OUT_BITS-1:0]   bin_count_reg;
    logic [BAR_BITS-1:0]   bar_length_reg;
    logic                  printable_reg;
    logic [OUT_BITS-1:0]   total_count_reg;

    logic [IDX_BITS-1:0]   rd_idx;
    logic [IDX_BITS-1:0]   wr_idx;
    logic                  in_range;
    logic [COUNT_BITS-1:0] cnt_eff;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  do_inc;
    logic                  rem_ge;

    assign rd_idx   = byte_value[IDX_BITS-1:0];
    assign wr_idx   = byte_reg[IDX_BITS-1:0];
    assign in_range = ({1'b0, byte_value} < (BYTE_BITS + 1)'(NUM_BINS));
    assign cnt_eff  = (rd_valid_reg && in_range_reg) ? rd_data_reg : '0;
    assign cnt_inc  = COUNT_BITS'(cnt_eff + COUNT_BITS'(1));
    assign do_inc   = cmd.update && in_range_reg && (cnt_eff != COUNT_MAX);
    assign rem_ge   = (rem_reg >= divr_reg);

    always_ff @(posedge clk)
    begin
        if (do_inc)
        begin
            mem[wr_idx] <= cnt_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_data_reg  <= mem[rd_idx];
            rd_valid_reg <= valid_reg[rd_idx];
            byte_reg     <= byte_value;
            in_range_reg <= in_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            largest_reg <= '0;
            total_reg   <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.clear)
            begin
                valid_reg   <= '0;
                largest_reg <= '0;
                total_reg   <= '0;
            end
            else if (do_inc)
            begin
                valid_reg[wr_idx] <= 1'b1;
                if (cnt_inc > largest_reg)
                begin
                    largest_reg <= cnt_inc;
                end
                if (total_reg != COUNT_MAX)
                begin
                    total_reg <= COUNT_BITS'(total_reg + COUNT_BITS'(1));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            rem_reg      <= PROD_BITS'(PROD_BITS'(bar_width) * PROD_BITS'(cnt_eff));
            divr_reg     <= PROD_BITS'(PROD_BITS'(largest_reg) << (BAR_BITS - 1));
            zero_div_reg <= (largest_reg == '0);
            count_reg    <= cnt_eff;
            quot_reg     <= '0;
        end
        else if (cmd.div)
        begin
            if (rem_ge)
            begin
                rem_reg <= PROD_BITS'(rem_reg - divr_reg);
            end
            quot_reg <= {quot_reg[BAR_BITS-2:0], rem_ge};
            divr_reg <= divr_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            bin_index_reg   <= byte_reg;
            bin_count_reg   <= sat_out(count_reg);
            bar_length_reg  <= zero_div_reg ? '0 : quot_reg;
            printable_reg   <= (byte_reg >= PRINT_LO) && (byte_reg <= PRINT_HI);
            total_count_reg <= sat_out(total_reg);
        end
    end

    assign done        = done_reg;
    assign bin_index   = bin_index_reg;
    assign bin_count   = bin_count_reg;
    assign bar_length  = bar_length_reg;
    assign printable   = printable_reg;
    assign total_count = total_count_reg;

endmodule

`default_nettype wire

>>> hw/rtl/byte_histogram_bar_scaler_top.sv
// Top level of the byte histogram bar scaler.
//
// channel   direction  handshake                  payload
// ------------------------------------------------------------------------------
// item in   in         start high, busy low       action, byte_value
// result    out        done strobe, one cycle     bin_index, bin_count, bar_length,
//                                                 printable, total_count
// config    in         APB, psel&penable&pwrite   paddr, pwdata, prdata (pready=1)
//
// A count item reads the store, then writes back; a clear item never raises busy, and
// action 3 is dropped. A query runs store read, bar multiply, 6 restoring divide
// steps of one quotient bit each, and output register; done rises as the outputs are
// loaded. Reset clears the bin valid bits, largest and total at once, with no clearing
// pass. Results cannot be stalled.
`default_nettype none

module byte_histogram_bar_scaler_top
    import bhbs_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           action,
    input  wire logic [BYTE_BITS-1:0] byte_value,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output logic                      done,
    output logic      [BYTE_BITS-1:0] bin_index,
    output logic      [OUT_BITS-1:0]  bin_count,
    output logic      [BAR_BITS-1:0]  bar_length,
    output logic                      printable,
    output logic      [OUT_BITS-1:0]  total_count
);

    bhbs_cmd_t           cmd;
    logic [BAR_BITS-1:0] bar_width;

    bhbs_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .bar_width (bar_width)
    );

    bhbs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .cmd    (cmd)
    );

    bhbs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .byte_value  (byte_value),
        .bar_width   (bar_width),
        .done        (done),
        .bin_index   (bin_index),
        .bin_count   (bin_count),
        .bar_length  (bar_length),
        .printable   (printable),
        .total_count (total_count)
    );

`ifndef SYNTHESIS
    a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_QUERY)) |-> ##9 done)
        else $error("query result missing");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without an accepted item");

    a_bar_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (bar_length != '0)) |-> (bin_count != '0))
        else $error("bar length without count");
`endif

endmodule

`default_nettype wire

>>> tb/byte_histogram_bar_scaler_top_tb.sv
// Self-checking bench for the byte histogram bar scaler: APB setup, directed and random items.

module byte_histogram_bar_scaler_top_tb;
    import bhbs_pkg::*;

    localparam int HOLD_CYCLES  = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int SHOWN_FAULTS = 10;

    localparam logic [2:0] ADDR_BAR_WIDTH = 3'd0;
    localparam logic [2:0] ADDR_SPARE     = 3'd4;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam logic [BAR_BITS-1:0] BAR_FULL = 6'd63;

    typedef struct packed {
        logic [BYTE_BITS-1:0] bin_index;
        logic [OUT_BITS-1:0]  bin_count;
        logic [BAR_BITS-1:0]  bar_length;
        logic                 printable;
        logic [OUT_BITS-1:0]  total_count;
    } bar_report_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           action;
    logic [BYTE_BITS-1:0] byte_value;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 done;
    logic [BYTE_BITS-1:0] bin_index;
    logic [OUT_BITS-1:0]  bin_count;
    logic [BAR_BITS-1:0]  bar_length;
    logic                 printable;
    logic [OUT_BITS-1:0]  total_count;

    logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
    logic [COUNT_BITS-1:0] peak_tally;
    logic [COUNT_BITS-1:0] grand_tally;
    logic [BAR_BITS-1:0]   bar_scale;

    bar_report_t expected_reports [$];

    int sender_idle_pct = 0;
    int fault_count     = 0;
    int items_sent      = 0;
    int queries_sent    = 0;
    int reports_checked = 0;
    int width_settings  = 0;
    int quiet_cycles    = 0;

    byte_histogram_bar_scaler_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .byte_value  (byte_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .done        (done),
        .bin_index   (bin_index),
        .bin_count   (bin_count),
        .bar_length  (bar_length),
        .printable   (printable),
        .total_count (total_count)
    );

    always #5 clk = ~clk;

    function automatic void empty_histogram();
        for (int i = 0; i < NUM_BINS; i++)
        begin
            bin_tally[i] = '0;
        end
        peak_tally  = '0;
        grand_tally = '0;
    endfunction

    function automatic logic [OUT_BITS-1:0] clip_count(input logic [COUNT_BITS-1:0] v);
        return (64'(v) > 64'hFFFF_FFFF) ? '1 : OUT_BITS'(v);
    endfunction

    // Advance the histogram by one item; return 1 when it yields a report.
    function automatic bit histogram_step(input logic [1:0] act,
                                          input logic [BYTE_BITS-1:0] b,
                                          output bar_report_t rep);
        logic [COUNT_BITS-1:0] cnt;
        logic [63:0]           bar;
        rep = '0;
        case (act)
            ACT_COUNT:
            begin
                if (int'(b) < NUM_BINS && bin_tally[b] != '1)
                begin
                    bin_tally[b] = bin_tally[b] + 1'b1;
                    if (bin_tally[b] > peak_tally)
                    begin
                        peak_tally = bin_tally[b];
                    end
                    if (grand_tally != '1)
                    begin
                        grand_tally = grand_tally + 1'b1;
                    end
                end
                return 1'b0;
            end
            ACT_QUERY:
            begin
                cnt = (int'(b) < NUM_BINS) ? bin_tally[b] : '0;
                bar = '0;
                if (peak_tally != '0)
                begin
                    bar = (64'(bar_scale) * 64'(cnt)) / 64'(peak_tally);
                end
                if (bar > 64'(BAR_FULL))
                begin
                    bar = 64'(BAR_FULL);
                end
                rep.bin_index   = b;
                rep.bin_count   = clip_count(cnt);
                rep.bar_length  = bar[BAR_BITS-1:0];
                rep.printable   = (b >= 8'h20 && b <= 8'h7E);
                rep.total_count = clip_count(grand_tally);
                return 1'b1;
            end
            ACT_CLEAR:
            begin
                empty_histogram();
                return 1'b0;
            end
            default:
            begin
                return 1'b0;
            end
        endcase
    endfunction

    task automatic log_fault(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    always @(posedge clk)
    begin : check_reports
        bar_report_t seen;
        bar_report_t want;
        if (rst_n && done)
        begin
            seen.bin_index   = bin_index;
            seen.bin_count   = bin_count;
            seen.bar_length  = bar_length;
            seen.printable   = printable;
            seen.total_count = total_count;
            if (expected_reports.size() == 0)
            begin
                log_fault($sformatf("unexpected report: bin %02h count %0d bar %0d pr %0b total %0d",
                          seen.bin_index, seen.bin_count, seen.bar_length, seen.printable,
                          seen.total_count));
            end
            else
            begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (seen.bin_index !== want.bin_index || seen.bin_count !== want.bin_count ||
                    seen.bar_length !== want.bar_length || seen.printable !== want.printable ||
                    seen.total_count !== want.total_count)
                begin
                    log_fault($sformatf({"report mismatch: exp bin %02h count %0d bar %0d pr %0b ",
                              "total %0d, got bin %02h count %0d bar %0d pr %0b total %0d"},
                              want.bin_index, want.bin_count, want.bar_length, want.printable,
                              want.total_count, seen.bin_index, seen.bin_count, seen.bar_length,
                              seen.printable, seen.total_count));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic issue_item(input logic [1:0] act, input logic [BYTE_BITS-1:0] b);
        bar_report_t rep;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        byte_value <= b;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (histogram_step(act, b, rep))
        begin
            expected_reports.push_back(rep);
            queries_sent++;
        end
    endtask

    // Hold the sender until every report is in, then let the block settle.
    task automatic settle_block();
        start <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (HOLD_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_BAR_WIDTH)
        begin
            bar_scale = data[BAR_BITS-1:0];
        end
    endtask

    task automatic apb_check_width();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_BAR_WIDTH;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[BAR_BITS-1:0] !== bar_scale)
        begin
            log_fault($sformatf("bar width readback: exp %0d got %0d",
                      bar_scale, prdata[BAR_BITS-1:0]));
        end
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_bar_width(input logic [BAR_BITS-1:0] w);
        settle_block();
        apb_write(ADDR_BAR_WIDTH, ($urandom() & ~32'h3F) | 32'(w));
        if ($urandom_range(1) == 1)
        begin
            apb_write(ADDR_SPARE, $urandom());
        end
        apb_check_width();
        apb_release();
        width_settings++;
    endtask

    task automatic test_empty_store();
        sender_idle_pct = 0;
        apb_check_width();
        apb_release();
        issue_item(ACT_QUERY, 8'h00);
        issue_item(ACT_QUERY, 8'h7E);
        issue_item(ACT_QUERY, 8'hFF);
    endtask

    task automatic test_special_actions();
        repeat (3) issue_item(ACT_COUNT, 8'h41);
        issue_item(ACT_COUNT, 8'h20);
        issue_item(ACT_COUNT, 8'h7F);
        issue_item(ACT_COUNT, 8'h00);
        issue_item(ACT_COUNT, 8'hFF);
        issue_item(ACT_COUNT, 8'h1F);
        issue_item(ACT_UNUSED, 8'h41);
        issue_item(ACT_UNUSED, 8'hFF);
        issue_item(ACT_QUERY, 8'h41);
        issue_item(ACT_QUERY, 8'h20);
        issue_item(ACT_QUERY, 8'h7F);
        issue_item(ACT_QUERY, 8'h1F);
        issue_item(ACT_QUERY, 8'hFF);
        issue_item(ACT_QUERY, 8'hAA);
        issue_item(ACT_CLEAR, 8'h55);
        issue_item(ACT_QUERY, 8'h41);
        issue_item(ACT_COUNT, 8'h55);
        issue_item(ACT_QUERY, 8'h55);
    endtask

    task automatic test_bar_extremes();
        logic [BAR_BITS-1:0] widths [4];
        widths = '{6'd0, 6'd1, 6'd63, 6'd37};
        foreach (widths[i])
        begin
            program_bar_width(widths[i]);
            issue_item(ACT_CLEAR, 8'($urandom()));
            repeat (5) issue_item(ACT_COUNT, 8'h10);
            repeat (2) issue_item(ACT_COUNT, 8'h11);
            issue_item(ACT_QUERY, 8'h10);
            issue_item(ACT_QUERY, 8'h11);
        end
    endtask

    task automatic test_random_phase(input int idle_pct, input int n_items,
                                     input logic [BAR_BITS-1:0] w);
        logic [BYTE_BITS-1:0] hot [6];
        logic [1:0]           act;
        logic [BYTE_BITS-1:0] b;
        int                   r;
        program_bar_width(w);
        sender_idle_pct = idle_pct;
        foreach (hot[i])
        begin
            hot[i] = 8'($urandom());
        end
        repeat (n_items)
        begin
            r = $urandom_range(99);
            if (r < 1)
            begin
                act = ACT_CLEAR;
            end
            else if (r < 3)
            begin
                act = ACT_UNUSED;
            end
            else if (r < 22)
            begin
                act = ACT_QUERY;
            end
            else
            begin
                act = ACT_COUNT;
            end
            b = ($urandom_range(99) < 60) ? hot[$urandom_range(5)] : 8'($urandom());
            issue_item(act, b);
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        action     <= ACT_COUNT;
        byte_value <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        empty_histogram();
        bar_scale = BAR_FULL;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_special_actions();
        test_bar_extremes();
        test_random_phase(0, 190, BAR_FULL);
        test_random_phase(87, 190, 6'($urandom()));
        test_random_phase(23, 190, 6'($urandom_range(1, 62)));
        test_random_phase(0, 180, 6'($urandom()));

        settle_block();
        if (expected_reports.size() != 0)
        begin
            log_fault($sformatf("%0d reports never arrived", expected_reports.size()));
        end
        $display("Ran %0d items (%0d queries), checked %0d reports, over %0d bar width settings.",
                 items_sent, queries_sent, reports_checked, width_settings);
        $display("Sender idled at 0, 87 and 23 percent; clears and unused actions mixed in.");
        if (fault_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("%0d faults", fault_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
